// File: sv/lsfc_pkg.sv
// Package with types, constants and codes of the latched serial frame capture block.
`default_nettype none
package lsfc_pkg;

  // Ring buffer geometry.
  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned AW         = $clog2(RING_DEPTH);

  // Field widths.
  localparam int unsigned QT_W    = 16;
  localparam int unsigned FB_W    = 10;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned CIDX_W  = 8;
  localparam int unsigned CDAT_W  = 32;

  // Register reset values.
  localparam logic [QT_W-1:0] QUALIFY_TICKS_RST = 16'd300;
  localparam logic [FB_W-1:0] FRAME_BITS_RST    = 10'd96;

  // Register indexes.
  localparam logic [CIDX_W-1:0] CFG_QUALIFY_TICKS = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_BITS    = 8'd1;

  // Command and result kind codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_QUALIFY = 2'd1,
    PH_CAPTURE = 2'd2
  } phase_e;

  typedef struct packed {
    logic             cmd;
    logic             latch_level;
    logic             clock_level;
    logic             data_level;
    logic [POS_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [POS_W-1:0]   frame_begin;
    logic [POS_W-1:0]   frame_end;
    logic [TOTAL_W-1:0] frame_total;
    logic               read_bit;
  } out_item_t;

  typedef struct packed {
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;
  } cfg_item_t;

  // Write and read requests toward the bit memory.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic          wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

// File: sv/lsfc_ifs.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
`default_nettype none
interface lsfc_in_if;
  logic               valid;
  logic               ready;
  lsfc_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lsfc_out_if;
  logic                valid;
  logic                ready;
  lsfc_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lsfc_cfg_if;
  logic                valid;
  logic                ready;
  lsfc_pkg::cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/latched_serial_frame_capture.sv
// Top level of the latched serial frame capture block.
//
//   channel   | dir | payload               | transaction
//   sample_i  | in  | in_item_t             | pin sample tick or buffer read request
//   result_o  | out | out_item_t            | frame report or read reply
//   cfg_i     | in  | cfg_item_t            | register write, always ready
//
// One sample or read request is accepted every cycle while stage one is free or
// advancing. A result passes the registered memory read and stage one, then the
// output register. Reset clears all control state; the buffer itself is not swept, a
// wrap flag and the write pointer mark which entries were written, and unwritten
// entries read as zero. A stalled output holds one result in the output register
// and one in the stage before it before the input channel drops ready.
`default_nettype none
module latched_serial_frame_capture (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lsfc_in_if.sink    sample_i,
  lsfc_out_if.source result_o,
  lsfc_cfg_if.sink   cfg_i
);
  import lsfc_pkg::*;

  // Configuration registers.
  logic [QT_W-1:0] qualify_ticks_q;
  logic [FB_W-1:0] frame_bits_q;

  // Capture state.
  phase_e             phase_q, phase_d;
  logic               prev_latch_q, prev_latch_d;
  logic               prev_clock_q, prev_clock_d;
  logic [QT_W-1:0]    qualify_count_q, qualify_count_d;
  logic [FB_W-1:0]    bit_count_q, bit_count_d;
  logic [AW-1:0]      write_ptr_q, write_ptr_d;
  logic               wrapped_q, wrapped_d;
  logic [AW-1:0]      frame_start_q, frame_start_d;
  logic [AW-1:0]      last_begin_q, last_begin_d;
  logic [AW-1:0]      last_end_q, last_end_d;
  logic [TOTAL_W-1:0] frame_counter_q, frame_counter_d;

  // Result pipeline.
  logic               s1_valid_q;
  logic               s1_kind_q;
  logic               s1_fill_q;
  logic [POS_W-1:0]   s1_begin_q, s1_end_q;
  logic [TOTAL_W-1:0] s1_total_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic       s1_adv, in_acc, smp, rd_req;
  logic       rise, fall, start_cap, frame_done, fill_ok;
  logic [QT_W-1:0] qc_inc;
  logic [FB_W-1:0] bc_inc;
  logic [AW-1:0]   wp_inc, rd_pos;
  ram_req_t   ram_req;
  logic       ram_rdata;

  // Handshakes.
  assign s1_adv         = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || s1_adv;
  assign in_acc         = sample_i.valid && sample_i.ready;
  assign smp            = in_acc && (sample_i.payload.cmd == CMD_SAMPLE);
  assign rd_req         = in_acc && (sample_i.payload.cmd == CMD_READ);
  assign cfg_i.ready    = 1'b1;

  // Edge detection and counter increments.
  assign rise   = !prev_latch_q && sample_i.payload.latch_level;
  assign fall   = prev_clock_q && !sample_i.payload.clock_level;
  assign qc_inc = qualify_count_q + 16'd1;
  assign bc_inc = bit_count_q + 10'd1;
  assign wp_inc = (write_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : write_ptr_q + AW'(1);

  assign start_cap = smp && (
      (phase_q == PH_IDLE && rise && qualify_ticks_q == '0) ||
      (phase_q == PH_QUALIFY && sample_i.payload.latch_level && qc_inc >= qualify_ticks_q));
  assign frame_done = smp && (phase_q == PH_CAPTURE) && fall && (bc_inc == frame_bits_q);

  // The read index field is exactly as wide as the ring address.
  assign rd_pos  = AW'(sample_i.payload.read_index);
  assign fill_ok = wrapped_q || (rd_pos < write_ptr_q);

  // Phase next state.
  always_comb begin
    phase_d = phase_q;
    if (smp) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rise) begin
            phase_d = (qualify_ticks_q == '0) ? PH_CAPTURE : PH_QUALIFY;
          end
        end
        PH_QUALIFY: begin
          if (!sample_i.payload.latch_level) begin
            phase_d = PH_IDLE;
          end else if (start_cap) begin
            phase_d = PH_CAPTURE;
          end
        end
        PH_CAPTURE: begin
          if (frame_done) begin
            phase_d = PH_IDLE;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Datapath updates and memory requests for an accepted transaction.
  always_comb begin
    prev_latch_d    = prev_latch_q;
    prev_clock_d    = prev_clock_q;
    qualify_count_d = qualify_count_q;
    bit_count_d     = bit_count_q;
    write_ptr_d     = write_ptr_q;
    wrapped_d       = wrapped_q;
    frame_start_d   = frame_start_q;
    last_begin_d    = last_begin_q;
    last_end_d      = last_end_q;
    frame_counter_d = frame_counter_q;
    ram_req.we      = 1'b0;
    ram_req.waddr   = write_ptr_q;
    ram_req.wdata   = sample_i.payload.data_level;
    ram_req.re      = rd_req;
    ram_req.raddr   = rd_pos;
    if (smp) begin
      prev_latch_d = sample_i.payload.latch_level;
      if (phase_q == PH_IDLE && rise) begin
        qualify_count_d = '0;
      end
      if (phase_q == PH_QUALIFY && sample_i.payload.latch_level) begin
        qualify_count_d = qc_inc;
      end
      if (phase_q == PH_CAPTURE) begin
        prev_clock_d = sample_i.payload.clock_level;
        if (fall) begin
          ram_req.we  = 1'b1;
          write_ptr_d = wp_inc;
          bit_count_d = bc_inc;
          if (write_ptr_q == AW'(RING_DEPTH - 1)) begin
            wrapped_d = 1'b1;
          end
        end
        if (frame_done) begin
          last_begin_d    = frame_start_q;
          last_end_d      = wp_inc;
          frame_counter_d = frame_counter_q + 32'd1;
        end
      end
      if (start_cap) begin
        prev_clock_d  = 1'b0;
        bit_count_d   = '0;
        frame_start_d = write_ptr_q;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qualify_ticks_q <= QUALIFY_TICKS_RST;
      frame_bits_q    <= FRAME_BITS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        CFG_QUALIFY_TICKS: qualify_ticks_q <= cfg_i.payload.data[QT_W-1:0];
        CFG_FRAME_BITS:    frame_bits_q    <= cfg_i.payload.data[FB_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      prev_latch_q    <= 1'b0;
      prev_clock_q    <= 1'b0;
      qualify_count_q <= '0;
      bit_count_q     <= '0;
      write_ptr_q     <= '0;
      wrapped_q       <= 1'b0;
      frame_start_q   <= '0;
      last_begin_q    <= '0;
      last_end_q      <= '0;
      frame_counter_q <= '0;
    end else begin
      phase_q         <= phase_d;
      prev_latch_q    <= prev_latch_d;
      prev_clock_q    <= prev_clock_d;
      qualify_count_q <= qualify_count_d;
      bit_count_q     <= bit_count_d;
      write_ptr_q     <= write_ptr_d;
      wrapped_q       <= wrapped_d;
      frame_start_q   <= frame_start_d;
      last_begin_q    <= last_begin_d;
      last_end_q      <= last_end_d;
      frame_counter_q <= frame_counter_d;
    end
  end

  // Ring buffer. A read and a write never share a cycle, so no forwarding is needed.
  lsfc_bit_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Stage one waits for the memory read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rd_req || frame_done) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req || frame_done) begin
      s1_kind_q  <= rd_req ? KIND_READ : KIND_FRAME;
      s1_fill_q  <= fill_ok;
      s1_begin_q <= POS_W'(last_begin_d);
      s1_end_q   <= POS_W'(last_end_d);
      s1_total_q <= frame_counter_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.kind        <= s1_kind_q;
      out_q.frame_begin <= s1_begin_q;
      out_q.frame_end   <= s1_end_q;
      out_q.frame_total <= s1_total_q;
      out_q.read_bit    <= (s1_kind_q == KIND_READ) && s1_fill_q && ram_rdata;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

`ifndef NO_ASSERTIONS
  // A completed frame advances the frame count by exactly one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> frame_counter_q == $past(frame_counter_q) + 32'd1)
    else $error("frame count did not advance on a completed frame");

  // The memory never sees a read and a write in the same cycle.
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("ring buffer read and write collided");

  // Every accepted read request occupies stage one in the next cycle.
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req |=> s1_valid_q && s1_kind_q == KIND_READ)
    else $error("read request did not reach stage one");
`endif

endmodule
`default_nettype wire

// File: sv/lsfc_bit_ram.sv
// One-bit-wide ring buffer memory with one write port and one registered read port.
`default_nettype none
module lsfc_bit_ram (
  input  wire logic               clk_i,
  input  wire lsfc_pkg::ram_req_t req_i,
  output logic                    rdata_o
);
  import lsfc_pkg::*;

  logic mem [RING_DEPTH];
  logic rdata_q;

  // Write and read in the same clocked block; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
